// ===== src/context_frequency_rank_codec_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the context frequency rank codec
// Concurrent checks switched out under synthesis.
// ----------------------------------------------------------------------------
`ifndef CONTEXT_FREQUENCY_RANK_CODEC_DEFINES_SVH
`define CONTEXT_FREQUENCY_RANK_CODEC_DEFINES_SVH
`ifndef SYNTHESIS
`define CFRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CFRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CFRC_ASSERT(lbl, prop, msg)
`define CFRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/cfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Context frequency rank codec package
// Sequencer states and fixed byte constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cfrc_pkg;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 9;

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b0000_0000_0001,
    ST_IDLE     = 12'b0000_0000_0010,
    ST_LEN      = 12'b0000_0000_0100,
    ST_SCAN_RD  = 12'b0000_0000_1000,
    ST_SCAN_CHK = 12'b0000_0001_0000,
    ST_PICK     = 12'b0000_0010_0000,
    ST_BUMP     = 12'b0000_0100_0000,
    ST_APPEND   = 12'b0000_1000_0000,
    ST_BUB_RD   = 12'b0001_0000_0000,
    ST_BUB_CHK  = 12'b0010_0000_0000,
    ST_FIN_WR   = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } state_e;
endpackage

// ===== src/cfrc_ram.sv =====
// ----------------------------------------------------------------------------
// Context frequency rank codec RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cfrc_ram #(
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/context_frequency_rank_codec.sv =====
// ----------------------------------------------------------------------------
// Context frequency rank codec
// Order-n context frequency rank transform over a byte stream.
// ----------------------------------------------------------------------------
// One request at a time. A pass-through prefix byte goes straight to the output.
// A coded byte costs a list read and a check per list entry scanned, plus a
// read and a write per place the entry moves forward, plus a search through
// the byte values for an unseen symbol when decoding a new symbol; the cost is
// set by the single read port of the list RAM. After reset a clearing pass over
// the length table runs before the first request is taken.
`timescale 1ns / 1ps
`include "context_frequency_rank_codec_defines.svh"
module context_frequency_rank_codec #(
  parameter int unsigned CONTEXT_ORDER = 1,
  parameter int unsigned FREQ_WIDTH    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o
);
  import cfrc_pkg::*;

  localparam int unsigned CtxW = 8 * CONTEXT_ORDER;
  localparam int unsigned LAW  = CtxW + ByteW;
  localparam int unsigned EntW = ByteW + FREQ_WIDTH;

  state_e state_q, state_d;

  logic              mode_q;
  logic [CtxW-1:0]   ctx_q;
  logic [1:0]        pre_q;
  logic [CtxW:0]     clr_q;
  logic              out_valid_q;
  logic [ByteW-1:0]  out_byte_q;

  logic [ByteW-1:0]      x_q;
  logic [LenW-1:0]       len_q;
  logic [LenW-1:0]       j_q;
  logic [ByteW-1:0]      smaller_q;
  logic [ByteW-1:0]      p_q;
  logic [ByteW-1:0]      ent_sym_q;
  logic [FREQ_WIDTH-1:0] ent_freq_q;
  logic [ByteW-1:0]      res_q;
  logic [ByteW-1:0]      plain_q;
  logic [255:0]          seen_q;
  logic [ByteW-1:0]      cnt_q;
  logic [ByteW-1:0]      s_q;

  logic                  lw_en;
  logic [LAW-1:0]        lw_addr;
  logic [EntW-1:0]       lw_data;
  logic [LAW-1:0]        lr_addr;
  logic [EntW-1:0]       lr_data;
  logic [ByteW-1:0]      rd_sym;
  logic [FREQ_WIDTH-1:0] rd_freq;

  logic                  nw_en;
  logic [CtxW-1:0]       nw_addr;
  logic [LenW-1:0]       nw_data;
  logic [LenW-1:0]       nr_data;

  logic in_acc, out_acc, out_load, hit, ahead, freq_max;
  logic [ByteW-1:0] want;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign rd_sym   = lr_data[EntW-1 -: ByteW];
  assign rd_freq  = lr_data[FREQ_WIDTH-1:0];
  assign hit      = mode_q ? (j_q == {1'b0, x_q}) : (rd_sym == x_q);
  assign ahead    = (ent_freq_q > rd_freq) ||
                    ((ent_freq_q == rd_freq) && (ent_sym_q < rd_sym));
  assign freq_max = (ent_freq_q == {FREQ_WIDTH{1'b1}});
  assign want     = 8'(x_q - len_q[ByteW-1:0]);

  assign lr_addr = (state_q == ST_BUB_RD) ? {ctx_q, 8'(p_q - 8'd1)} : {ctx_q, j_q[ByteW-1:0]};
  assign lw_en   = ((state_q == ST_BUB_CHK) && ahead) || (state_q == ST_FIN_WR);
  assign lw_addr = {ctx_q, p_q};
  assign lw_data = (state_q == ST_BUB_CHK) ? lr_data : {ent_sym_q, ent_freq_q};

  assign nw_en   = (state_q == ST_CLEAR) || (state_q == ST_APPEND);
  assign nw_addr = (state_q == ST_CLEAR) ? clr_q[CtxW-1:0] : ctx_q;
  assign nw_data = (state_q == ST_CLEAR) ? '0 : LenW'(len_q + 9'd1);

  cfrc_ram #(.AddrW(LAW), .DataW(EntW)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lw_en),
    .waddr_i (lw_addr),
    .wdata_i (lw_data),
    .raddr_i (lr_addr),
    .rdata_o (lr_data)
  );

  cfrc_ram #(.AddrW(CtxW), .DataW(LenW)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (nw_en),
    .waddr_i (nw_addr),
    .wdata_i (nw_data),
    .raddr_i (ctx_q),
    .rdata_o (nr_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_q[CtxW]) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (pre_q < 2'(CONTEXT_ORDER)) ? ST_DONE : ST_LEN;
        end
      end
      ST_LEN:      state_d = ST_SCAN_RD;
      ST_SCAN_RD: begin
        if (j_q == len_q) state_d = mode_q ? ST_PICK : ST_APPEND;
        else state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: state_d = hit ? ST_BUMP : ST_SCAN_RD;
      ST_PICK:     if (!seen_q[s_q] && (cnt_q == want)) state_d = ST_APPEND;
      ST_BUMP:     state_d = freq_max ? ST_DONE : ST_BUB_RD;
      ST_APPEND:   state_d = ST_BUB_RD;
      ST_BUB_RD:   state_d = (p_q == '0) ? ST_FIN_WR : ST_BUB_CHK;
      ST_BUB_CHK:  state_d = ahead ? ST_BUB_RD : ST_FIN_WR;
      ST_FIN_WR:   state_d = ST_DONE;
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= 1'b0;
      ctx_q       <= '0;
      pre_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (in_acc && (pre_q < 2'(CONTEXT_ORDER))) pre_q <= pre_q + 2'd1;
      if (out_load) begin
        ctx_q       <= CtxW'({ctx_q, plain_q});
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_byte_q <= res_q;
    unique case (state_q)
      ST_IDLE: begin
        x_q     <= in_byte_i;
        res_q   <= in_byte_i;
        plain_q <= in_byte_i;
      end
      ST_LEN: begin
        len_q     <= nr_data;
        smaller_q <= '0;
        seen_q    <= '0;
        cnt_q     <= '0;
        s_q       <= '0;
        j_q       <= (mode_q && ({1'b0, x_q} < nr_data)) ? {1'b0, x_q} : '0;
      end
      ST_SCAN_RD: begin
        if ((j_q == len_q) && !mode_q) begin
          res_q <= 8'(len_q[ByteW-1:0] + x_q - smaller_q);
        end
      end
      ST_SCAN_CHK: begin
        seen_q[rd_sym] <= 1'b1;
        if (hit) begin
          ent_sym_q  <= rd_sym;
          ent_freq_q <= rd_freq;
          p_q        <= j_q[ByteW-1:0];
          plain_q    <= rd_sym;
          res_q      <= mode_q ? rd_sym : j_q[ByteW-1:0];
        end else begin
          smaller_q <= smaller_q + ByteW'(rd_sym < x_q);
          j_q       <= j_q + 9'd1;
        end
      end
      ST_PICK: begin
        if (!seen_q[s_q]) begin
          if (cnt_q == want) begin
            plain_q <= s_q;
            res_q   <= s_q;
          end else begin
            cnt_q <= cnt_q + 8'd1;
          end
        end
        s_q <= s_q + 8'd1;
      end
      ST_BUMP:     ent_freq_q <= ent_freq_q + FREQ_WIDTH'(1);
      ST_APPEND: begin
        ent_sym_q  <= plain_q;
        ent_freq_q <= FREQ_WIDTH'(1);
        p_q        <= len_q[ByteW-1:0];
      end
      ST_BUB_CHK:  if (ahead) p_q <= p_q - 8'd1;
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  `CFRC_ASSERT(a_bub_nonzero, (state_q == ST_BUB_CHK) |-> (p_q != '0), "bubble past head")
  `CFRC_ASSERT(a_list_we, lw_en |-> ((state_q == ST_BUB_CHK) || (state_q == ST_FIN_WR)), "stray list write")
  `CFRC_ASSERT(a_len_room, (state_q == ST_APPEND) |-> (len_q < 9'd256), "append to full list")
  `CFRC_ASSERT(a_onehot, $onehot(state_q), "state not one-hot")
endmodule
